@@ hdl/packed_to_planar_rect_transfer_unit_assert.svh @@
// ----------------------------------------------------------------------------
// Packed-to-planar transfer: assertion macros
// Concurrent check wrappers, compiled out for synthesis.
// ----------------------------------------------------------------------------
`ifndef PACKED_TO_PLANAR_RECT_TRANSFER_UNIT_ASSERT_SVH
`define PACKED_TO_PLANAR_RECT_TRANSFER_UNIT_ASSERT_SVH

`ifndef SYNTHESIS

// property must hold at every edge outside reset
`define P2PR_ASSERT(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error("p2pr check failed");

// condition must never be seen outside reset
`define P2PR_NEVER(lbl, clk, rst_n, cond) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
		else $error("p2pr forbidden condition");

`else

`define P2PR_ASSERT(lbl, clk, rst_n, prop)
`define P2PR_NEVER(lbl, clk, rst_n, cond)

`endif

`endif

@@ hdl/p2pr_pkg.sv @@
// ----------------------------------------------------------------------------
// Packed-to-planar transfer: shared package
// Widths, register indexes and the structs passed between modules.
// ----------------------------------------------------------------------------
package p2pr_pkg;

	localparam int ADDR_BITS  = 16;
	localparam int ADDR_OUT_W = 16;
	localparam int NUM_PLANES = 4;
	localparam int PLANE_W    = $clog2(NUM_PLANES);
	localparam int WORD_W     = 32;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 11;

	// register indexes of the configuration port
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_LINE_PITCH  = 3'd0,
		REG_RECT_LEFT   = 3'd1,
		REG_RECT_TOP    = 3'd2,
		REG_RECT_RIGHT  = 3'd3,
		REG_RECT_BOTTOM = 3'd4,
		REG_DIRECTION   = 3'd5
	} reg_idx_t;

	// direction codes
	localparam logic DIR_READ  = 1'b0;
	localparam logic DIR_WRITE = 1'b1;

	typedef struct packed {
		logic [9:0]  line_pitch;
		logic [10:0] rect_left;
		logic [9:0]  rect_top;
		logic [10:0] rect_right;
		logic [9:0]  rect_bottom;
		logic        direction;
	} cfg_t;

	// walker status towards the top level
	typedef struct packed {
		logic [ADDR_BITS-1:0] addr;
		logic                 done;
		logic                 empty;
	} walk_t;

endpackage

@@ hdl/packed_to_planar_rect_transfer_unit.sv @@
// ----------------------------------------------------------------------------
// Packed-to-planar rectangle transfer unit
// Converts 4-bit packed pixel words to VGA plane writes and back.
// ----------------------------------------------------------------------------
// Each input word covers one group of eight pixels of the rectangle. With
// direction set, a word yields four plane writes (planes 0 to 3, last on
// plane 3) issued one per cycle from the output register while out_ready
// holds; with direction clear, four plane bytes yield one packed word.
// Four plane lanes convert the whole word at once; the output port, one
// result per cycle unless out_ready stalls it, sets the write-mode rate.
// The next word is taken while the previous one's results drain. A register
// write drops ready for one cycle while the rectangle start offset is
// recomputed, and restarts the walk at the rectangle's first group.
// Rectangles holding no whole group swallow words without results.
// ----------------------------------------------------------------------------
`include "packed_to_planar_rect_transfer_unit_assert.svh"

module packed_to_planar_rect_transfer_unit (
	input  logic                           clk,
	input  logic                           arst_n,
	// register port
	input  logic                           cfg_wr_en,
	input  logic [p2pr_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [p2pr_pkg::CFG_DATA_W-1:0] cfg_data,
	// input words
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic [p2pr_pkg::WORD_W-1:0]    data_word,
	// results
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic [p2pr_pkg::PLANE_W-1:0]   plane,
	output logic [p2pr_pkg::ADDR_OUT_W-1:0] address,
	output logic [7:0]                     plane_byte,
	output logic [p2pr_pkg::WORD_W-1:0]    packed_word,
	output logic                           last,
	output logic                           rect_done
);
	import p2pr_pkg::*;

	cfg_t  cfg_q;
	logic  cfg_busy_q;
	logic  restart_q;
	walk_t walk;

	// word held for conversion
	logic                 hold_v_q;
	logic [WORD_W-1:0]    hold_word_q;
	logic [ADDR_BITS-1:0] hold_addr_q;
	logic                 hold_done_q;
	logic                 hold_dir_q;
	logic [PLANE_W-1:0]   beat_q;

	// output register
	logic                  out_valid_q;
	logic [PLANE_W-1:0]    plane_q;
	logic [ADDR_OUT_W-1:0] address_q;
	logic [7:0]            plane_byte_q;
	logic [WORD_W-1:0]     packed_q;
	logic                  last_q;
	logic                  done_q;

	logic [7:0]        lane_byte [NUM_PLANES];
	logic [WORD_W-1:0] lane_part [NUM_PLANES];
	logic [WORD_W-1:0] packed_merge;

	logic restart;
	logic out_free;
	logic move;
	logic hold_last;
	logic accept;

	// register writes; the walk restarts from the registered restart flag, on the new settings
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.line_pitch  <= 10'd80;
			cfg_q.rect_left   <= 11'd0;
			cfg_q.rect_top    <= 10'd0;
			cfg_q.rect_right  <= 11'd640;
			cfg_q.rect_bottom <= 10'd480;
			cfg_q.direction   <= DIR_WRITE;
			cfg_busy_q        <= 1'b0;
			restart_q         <= 1'b0;
		end else begin
			cfg_busy_q <= cfg_wr_en;
			restart_q  <= restart;
			if (cfg_wr_en) begin
				unique case (reg_idx_t'(cfg_index))
					REG_LINE_PITCH:  cfg_q.line_pitch  <= cfg_data[9:0];
					REG_RECT_LEFT:   cfg_q.rect_left   <= cfg_data;
					REG_RECT_TOP:    cfg_q.rect_top    <= cfg_data[9:0];
					REG_RECT_RIGHT:  cfg_q.rect_right  <= cfg_data;
					REG_RECT_BOTTOM: cfg_q.rect_bottom <= cfg_data[9:0];
					REG_DIRECTION:   cfg_q.direction   <= cfg_data[0];
					default: ;
				endcase
			end
		end
	end

	// writes to indexes past the list leave the walk alone
	always_comb begin
		restart = 1'b0;
		if (cfg_wr_en) begin
			unique case (reg_idx_t'(cfg_index)) inside
				REG_LINE_PITCH, REG_RECT_LEFT, REG_RECT_TOP,
				REG_RECT_RIGHT, REG_RECT_BOTTOM, REG_DIRECTION: restart = 1'b1;
				default: restart = 1'b0;
			endcase
		end
	end

	// handshake between input, held word and output register
	assign out_free  = !out_valid_q || out_ready;
	assign move      = hold_v_q && out_free;
	assign hold_last = (hold_dir_q == DIR_READ) || (beat_q == PLANE_W'(NUM_PLANES - 1));
	assign in_ready  = !cfg_busy_q && (!hold_v_q || (move && hold_last));
	assign accept    = in_valid && in_ready;

	p2pr_walk u_walk (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg_q),
		.restart (restart_q),
		.step    (accept && !walk.empty),
		.info    (walk)
	);

	// held word and beat counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_v_q <= 1'b0;
			beat_q   <= '0;
		end else if (accept && !walk.empty) begin
			hold_v_q <= 1'b1;
			beat_q   <= '0;
		end else if (move) begin
			if (hold_last) begin
				hold_v_q <= 1'b0;
			end else begin
				beat_q <= beat_q + PLANE_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept && !walk.empty) begin
			hold_word_q <= data_word;
			hold_addr_q <= walk.addr;
			hold_done_q <= walk.done;
			hold_dir_q  <= cfg_q.direction;
		end
	end

	// plane lanes
	for (genvar g = 0; g < NUM_PLANES; g++) begin : g_lane
		p2pr_lane u_lane (
			.lane_id     (PLANE_W'(g)),
			.word        (hold_word_q),
			.plane_byte  (lane_byte[g]),
			.packed_part (lane_part[g])
		);
	end

	// merge: lanes fill disjoint bits of the packed word
	always_comb begin
		packed_merge = '0;
		for (int i = 0; i < NUM_PLANES; i++) begin
			packed_merge = packed_merge | lane_part[i];
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (move) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (move) begin
			address_q <= ADDR_OUT_W'(hold_addr_q);
			last_q    <= hold_last;
			done_q    <= hold_done_q;
			if (hold_dir_q == DIR_WRITE) begin
				plane_q      <= beat_q;
				plane_byte_q <= lane_byte[beat_q];
				packed_q     <= '0;
			end else begin
				plane_q      <= '0;
				plane_byte_q <= '0;
				packed_q     <= packed_merge;
			end
		end
	end

	assign out_valid   = out_valid_q;
	assign plane       = plane_q;
	assign address     = address_q;
	assign plane_byte  = plane_byte_q;
	assign packed_word = packed_q;
	assign last        = last_q;
	assign rect_done   = done_q;

	`P2PR_ASSERT(a_read_single_beat, clk, arst_n, (hold_v_q && hold_dir_q == DIR_READ) |-> beat_q == '0)
	`P2PR_ASSERT(a_beat_advances, clk, arst_n, (move && !hold_last) |=> (hold_v_q && beat_q == $past(beat_q) + PLANE_W'(1)))
	`P2PR_ASSERT(a_busy_after_write, clk, arst_n, cfg_wr_en |=> !in_ready)
	`P2PR_NEVER(a_write_beat_has_packed, clk, arst_n, out_valid_q && plane_q != '0 && packed_q != '0)

endmodule

@@ hdl/p2pr_lane.sv @@
// ----------------------------------------------------------------------------
// Packed-to-planar transfer: plane lane
// One plane's share of the conversion, both directions.
// ----------------------------------------------------------------------------
module p2pr_lane (
	input  logic [p2pr_pkg::PLANE_W-1:0] lane_id,
	input  logic [p2pr_pkg::WORD_W-1:0]  word,
	output logic [7:0]                   plane_byte,
	output logic [p2pr_pkg::WORD_W-1:0]  packed_part
);
	import p2pr_pkg::*;

	logic [7:0] plane_in;

	// this plane's byte in a read word
	assign plane_in = word[8*lane_id +: 8];

	// write: gather bit lane_id (right pixel) and lane_id+4 (left pixel) of each byte
	// read: scatter the plane byte back into the nibbles of the packed word
	always_comb begin
		plane_byte  = '0;
		packed_part = '0;
		for (int k = 0; k < 4; k++) begin
			plane_byte[7-2*k]              = word[8*k + 4 + lane_id];
			plane_byte[6-2*k]              = word[8*k + lane_id];
			packed_part[8*k + 4 + lane_id] = plane_in[7-2*k];
			packed_part[8*k + lane_id]     = plane_in[6-2*k];
		end
	end

endmodule

@@ hdl/p2pr_walk.sv @@
// ----------------------------------------------------------------------------
// Packed-to-planar transfer: rectangle walker
// Group and line counters, plane offset of the current group.
// ----------------------------------------------------------------------------
`include "packed_to_planar_rect_transfer_unit_assert.svh"

module p2pr_walk (
	input  logic            clk,
	input  logic            arst_n,
	input  p2pr_pkg::cfg_t  cfg,
	input  logic            restart,
	input  logic            step,
	output p2pr_pkg::walk_t info
);
	import p2pr_pkg::*;

	logic [ADDR_BITS-1:0] start_base_q;
	logic [7:0]           groups_q;
	logic [9:0]           lines_q;
	logic [ADDR_BITS-1:0] line_base_q;
	logic [7:0]           group_q;
	logic [9:0]           line_q;

	logic [19:0] top_prod;
	logic [20:0] start_sum;
	logic [10:0] col_span;
	logic [8:0]  group_nxt;
	logic [10:0] line_nxt;
	logic        group_wrap;
	logic        line_wrap;

	// rectangle geometry, registered from the settings every cycle
	assign top_prod  = 20'(cfg.rect_top) * 20'(cfg.line_pitch);
	assign start_sum = 21'(top_prod) + 21'(cfg.rect_left[10:3]);
	assign col_span  = cfg.rect_right - cfg.rect_left;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_base_q <= '0;
			groups_q     <= 8'd80;
			lines_q      <= 10'd480;
		end else begin
			start_base_q <= ADDR_BITS'(start_sum);
			groups_q     <= (cfg.rect_right > cfg.rect_left) ? col_span[10:3] : 8'd0;
			lines_q      <= (cfg.rect_bottom > cfg.rect_top) ?
			                (cfg.rect_bottom - cfg.rect_top) : 10'd0;
		end
	end

	assign group_nxt  = {1'b0, group_q} + 9'd1;
	assign line_nxt   = {1'b0, line_q} + 11'd1;
	assign group_wrap = group_nxt >= {1'b0, groups_q};
	assign line_wrap  = line_nxt >= {1'b0, lines_q};

	// walk along a line, then down by the pitch; start over after the last group
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			line_base_q <= '0;
			group_q     <= '0;
			line_q      <= '0;
		end else if (restart) begin
			line_base_q <= ADDR_BITS'(start_sum);
			group_q     <= '0;
			line_q      <= '0;
		end else if (step) begin
			if (group_wrap) begin
				group_q <= '0;
				if (line_wrap) begin
					line_base_q <= start_base_q;
					line_q      <= '0;
				end else begin
					line_base_q <= line_base_q + ADDR_BITS'(cfg.line_pitch);
					line_q      <= line_nxt[9:0];
				end
			end else begin
				group_q <= group_nxt[7:0];
			end
		end
	end

	assign info.addr  = line_base_q + ADDR_BITS'(group_q);
	assign info.done  = group_wrap && line_wrap;
	assign info.empty = (groups_q == 8'd0) || (lines_q == 10'd0);

	`P2PR_ASSERT(a_group_in_range, clk, arst_n, !info.empty |-> group_q < groups_q)
	`P2PR_ASSERT(a_line_in_range, clk, arst_n, !info.empty |-> line_q < lines_q)

endmodule
